@@ hdl/u8d_pkg.sv @@
// shared types, constants and decode helpers for the utf-8 stream decoder
`timescale 1ns / 1ps
`default_nettype none

package u8d_pkg;

  localparam int BYTE_W  = 8;
  localparam int CP_W    = 21;
  localparam int LEN_W   = 3;
  localparam int CNT_W   = 2;
  localparam int LIST_N  = 3;
  localparam int OUT_DW  = 24;

  localparam logic [CP_W-1:0]   CP_REPL   = 21'h00FFFD;
  localparam logic [BYTE_W-1:0] ASCII_END = 8'h80;
  localparam logic [BYTE_W-1:0] LEAD2_LO  = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD3_LO  = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD4_LO  = 8'hF0;

  localparam logic [LEN_W-1:0] LEN_1 = 3'd1;
  localparam logic [LEN_W-1:0] LEN_2 = 3'd2;
  localparam logic [LEN_W-1:0] LEN_3 = 3'd3;
  localparam logic [LEN_W-1:0] LEN_4 = 3'd4;

  typedef struct packed {
    logic [BYTE_W-1:0] text_byte;
    logic              end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            replaced;
    logic            run_last;
    logic            text_last;
  } res_t;

  typedef struct packed {
    res_t [LIST_N-1:0] ent;
    logic [CNT_W-1:0]  cnt;
  } res_list_t;

  // sequence length from the lead byte alone
  function automatic logic [LEN_W-1:0] seq_len(input logic [BYTE_W-1:0] b);
    logic [LEN_W-1:0] len;
    if (b inside {[LEAD4_LO:8'hFF]}) begin
      len = LEN_4;
    end else if (b inside {[LEAD3_LO:8'hEF]}) begin
      len = LEN_3;
    end else if (b inside {[LEAD2_LO:8'hDF]}) begin
      len = LEN_2;
    end else begin
      len = LEN_1;
    end
    return len;
  endfunction

  // lead keeps 0xff >> (len + 1), each trailer adds its low 6 bits
  function automatic logic [CP_W-1:0] assemble(input logic [LEN_W-1:0]  len,
                                               input logic [BYTE_W-1:0] b0,
                                               input logic [BYTE_W-1:0] b1,
                                               input logic [BYTE_W-1:0] b2,
                                               input logic [BYTE_W-1:0] b3);
    logic [CP_W-1:0] cp;
    case (len)
      LEN_2:   cp = {10'd0, b0[4:0], b1[5:0]};
      LEN_3:   cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
      default: cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
    endcase
    return cp;
  endfunction

  function automatic res_t mk_res(input logic [CP_W-1:0] cp, input logic rep);
    res_t r;
    r.code_point = cp;
    r.replaced   = rep;
    r.run_last   = 1'b0;
    r.text_last  = 1'b0;
    return r;
  endfunction

  // a lone byte at the end of a text: ascii passes, anything else is replaced
  function automatic res_t lone_res(input logic [BYTE_W-1:0] b);
    res_t r;
    if (b < ASCII_END) begin
      r = mk_res({13'd0, b}, 1'b0);
    end else begin
      r = mk_res(CP_REPL, 1'b1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hdl/utf8_stream_decoder_core.sv @@
// top level of the non-validating utf-8 stream decoder
//
//  channel  dir  handshake               tdata                      tuser     tlast
//  in_      in   in_tvalid / in_tready   [7:0] text_byte            -         end_of_text
//  out_     out  out_tvalid / out_tready [20:0] code_point,         replaced  text_last
//                                        [21] run_last, [23:22] 0
//
// one byte per cycle in steady state while out_tready is high: a byte is held
// in the input register, then decoded and loaded into the result register; a
// byte ending a text inside a sequence gives up to three results, drained one
// per cycle while out_tready is high, and the next byte with results waits
// in_tready comes from the skid entry, so it never depends on out_tready
// synchronous active-low reset empties both registers and the held sequence
`timescale 1ns / 1ps
`default_nettype none

module utf8_stream_decoder_core (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [u8d_pkg::BYTE_W-1:0]   in_tdata,   // [7:0] text_byte
  input  wire logic                         in_tlast,   // end_of_text
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic [u8d_pkg::OUT_DW-1:0]        out_tdata,  // [20:0] code_point, [21] run_last
  output logic                              out_tuser,  // replaced
  output logic                              out_tlast   // text_last
);
  import u8d_pkg::*;

  in_item_t  in_item;
  in_item_t  item;
  logic      item_valid;
  logic      take;
  logic      list_free;
  res_list_t rlist;
  res_t      out_res;

  assign in_item.text_byte   = in_tdata;
  assign in_item.end_of_text = in_tlast;

  // input register with skid entry
  u8d_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  // held sequence and decode of the registered byte
  u8d_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .list_free  (list_free),
    .take       (take),
    .rlist      (rlist)
  );

  // results of one byte, handed out in order
  u8d_out_queue u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .rlist     (rlist),
    .list_free (list_free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {2'b00, out_res.run_last, out_res.code_point};
  assign out_tuser = out_res.replaced;
  assign out_tlast = out_res.text_last;

endmodule

`default_nettype wire

@@ hdl/u8d_in_reg.sv @@
// input register with skid entry, keeps in_tready registered
`timescale 1ns / 1ps
`default_nettype none

module u8d_in_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire u8d_pkg::in_item_t in_item,
  input  wire logic              take,
  output logic                   item_valid,
  output u8d_pkg::in_item_t      item
);
  import u8d_pkg::*;

  logic     main_v_r, main_v_nxt;
  logic     skid_v_r, skid_v_nxt;
  in_item_t main_r, main_nxt;
  in_item_t skid_r, skid_nxt;
  logic     acc;

  assign in_ready   = !skid_v_r;
  assign acc        = in_valid && in_ready;
  assign item_valid = main_v_r;
  assign item       = main_r;

  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    if (take || !main_v_r) begin
      if (skid_v_r) begin
        main_v_nxt = 1'b1;
        main_nxt   = skid_r;
        skid_v_nxt = 1'b0;
      end else begin
        main_v_nxt = acc;
        main_nxt   = in_item;
      end
    end else if (acc) begin
      skid_v_nxt = 1'b1;
      skid_nxt   = in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

`default_nettype wire

@@ hdl/u8d_decode.sv @@
// sequence state and one-pass decode of an item into up to three results
`timescale 1ns / 1ps
`default_nettype none

module u8d_decode (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              item_valid,
  input  wire u8d_pkg::in_item_t item,
  input  wire logic              list_free,
  output logic                   take,
  output u8d_pkg::res_list_t     rlist
);
  import u8d_pkg::*;

  logic [BYTE_W-1:0] held_r [LIST_N];
  logic [BYTE_W-1:0] held_nxt [LIST_N];
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [LEN_W-1:0]  exp_r, exp_nxt;

  logic [BYTE_W-1:0] b;
  logic [BYTE_W-1:0] e0, e1, e2;
  logic [LEN_W-1:0]  cnt_inc;
  logic [CNT_W-1:0]  cnt_post;
  res_t              ent [LIST_N];
  logic [CNT_W-1:0]  n;

  assign b       = item.text_byte;
  assign cnt_inc = {1'b0, cnt_r} + LEN_1;
  // bytes of the sequence once this byte is placed
  assign e0 = (cnt_r == 2'd0) ? b : held_r[0];
  assign e1 = (cnt_r == 2'd1) ? b : held_r[1];
  assign e2 = (cnt_r == 2'd2) ? b : held_r[2];

  always_comb begin
    for (int k = 0; k < LIST_N; k++) begin
      held_nxt[k] = held_r[k];
      ent[k]      = mk_res(CP_REPL, 1'b1);
    end
    n        = 2'd0;
    cnt_post = cnt_r;
    exp_nxt  = exp_r;

    if (cnt_r == 2'd0) begin
      if (b < ASCII_END) begin
        ent[0] = mk_res({13'd0, b}, 1'b0);
        n      = 2'd1;
      end else if (b < LEAD2_LO) begin
        n = 2'd1;
      end else begin
        held_nxt[0] = b;
        cnt_post    = 2'd1;
        exp_nxt     = seq_len(b);
      end
    end else if (cnt_inc >= exp_r) begin
      ent[0]   = mk_res(assemble(exp_r, e0, e1, e2, b), 1'b0);
      n        = 2'd1;
      cnt_post = 2'd0;
      exp_nxt  = '0;
    end else begin
      held_nxt[cnt_r] = b;
      cnt_post        = cnt_inc[CNT_W-1:0];
    end

    // end of text inside a sequence: lead is replaced, the rest replayed
    if (item.end_of_text && cnt_post != 2'd0) begin
      ent[0] = mk_res(CP_REPL, 1'b1);
      case (cnt_post)
        2'd1: begin
          n = 2'd1;
        end
        2'd2: begin
          ent[1] = lone_res(e1);
          n      = 2'd2;
        end
        default: begin
          if (seq_len(e1) == LEN_2) begin
            ent[1] = mk_res(assemble(LEN_2, e1, e2, e2, e2), 1'b0);
            n      = 2'd2;
          end else begin
            ent[1] = lone_res(e1);
            ent[2] = lone_res(e2);
            n      = 2'd3;
          end
        end
      endcase
      cnt_post = 2'd0;
      exp_nxt  = '0;
    end

    for (int k = 0; k < LIST_N; k++) begin
      ent[k].run_last  = (n == CNT_W'(k + 1));
      ent[k].text_last = (n == CNT_W'(k + 1)) && item.end_of_text;
    end
    cnt_nxt = cnt_post;
  end

  assign take = item_valid && ((n == 2'd0) || list_free);

  always_comb begin
    for (int k = 0; k < LIST_N; k++) begin
      rlist.ent[k] = ent[k];
    end
    rlist.cnt = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      exp_r <= '0;
    end else if (take) begin
      cnt_r <= cnt_nxt;
      exp_r <= exp_nxt;
    end
    if (take) begin
      for (int k = 0; k < LIST_N; k++) begin
        held_r[k] <= held_nxt[k];
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/u8d_out_queue.sv @@
// result register: holds the results of one item and hands them out in order
`timescale 1ns / 1ps
`default_nettype none

module u8d_out_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               take,
  input  wire u8d_pkg::res_list_t rlist,
  output logic                    list_free,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output u8d_pkg::res_t           out_res
);
  import u8d_pkg::*;

  res_t             lst_r [LIST_N];
  res_t             lst_nxt [LIST_N];
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             fire;
  logic             load;

  assign out_valid = (cnt_r != 2'd0);
  assign out_res   = lst_r[0];
  assign fire      = out_valid && out_ready;
  assign list_free = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && fire);
  assign load      = take && (rlist.cnt != 2'd0);

  always_comb begin
    for (int k = 0; k < LIST_N; k++) begin
      lst_nxt[k] = lst_r[k];
    end
    cnt_nxt = cnt_r;
    if (load) begin
      for (int k = 0; k < LIST_N; k++) begin
        lst_nxt[k] = rlist.ent[k];
      end
      cnt_nxt = rlist.cnt;
    end else if (fire) begin
      for (int k = 0; k < LIST_N - 1; k++) begin
        lst_nxt[k] = lst_r[k+1];
      end
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    for (int k = 0; k < LIST_N; k++) begin
      lst_r[k] <= lst_nxt[k];
    end
  end

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// self-checking stream testbench for the non-validating utf-8 stream decoder
`timescale 1ns / 1ps

module tb_top;
  import u8d_pkg::*;

  localparam int PHASE_BYTES = 117;   // least bytes queued per phase, directed ones included
  localparam int QUIET_LIMIT = 2000;  // cycles with no item moving on either side
  localparam int DRAIN_CYCLES = 24;   // settle time once nothing is due any more

  // directed text, {end_of_text, text_byte} per entry
  localparam logic [8:0] DIRECTED [28] = '{
    9'h000, 9'h17F,                   // ascii extremes, second one ends a text
    9'h080, 9'h0BF,                   // stray continuation bytes
    9'h0C0, 9'h080,                   // overlong two-byte form of zero
    9'h0DF, 9'h0BF,                   // largest two-byte value
    9'h0EF, 9'h0BF, 9'h0BF,           // largest three-byte value
    9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF,   // largest code point the field can hold
    9'h0FF, 9'h041, 9'h000, 9'h03F,   // ascii bytes taken as trailers while holding
    9'h0F0, 9'h0C3, 9'h1A9,           // cut short, replay decodes an inner pair
    9'h0E2, 9'h141,                   // cut short, replay gives an ascii byte
    9'h1C5,                           // lone lead byte at the end of a text
    9'h0F0, 9'h080, 9'h1FF            // cut short, three replacements in a row
  };

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [BYTE_W-1:0]   in_tdata = '0;
  logic                in_tlast = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_DW-1:0]   out_tdata;
  logic                out_tuser;
  logic                out_tlast;

  // decoder state as the predictor sees it
  logic [BYTE_W-1:0]   seq_buf [4];
  int unsigned         seq_cnt = 0;
  int unsigned         seq_need = 0;

  in_item_t            text_q [$];         // bytes waiting for the driver
  res_t                code_points_due [$]; // predicted results, oldest first
  int unsigned         bytes_queued = 0;
  int unsigned         bytes_taken = 0;
  int unsigned         errors = 0;
  int unsigned         quiet_cycles = 0;
  int                  src_idle_pct = 0;
  int                  sink_stall_pct = 0;
  logic                in_fire = 1'b0;     // input item taken at the last rising edge

  always #5 clk = ~clk;

  utf8_stream_decoder_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // sequence length from the lead byte alone
  function automatic int unsigned lead_length(input logic [BYTE_W-1:0] b);
    if (b >= LEAD4_LO) return 4;
    if (b >= LEAD3_LO) return 3;
    if (b >= LEAD2_LO) return 2;
    return 1;
  endfunction

  // lead keeps its low bits under 0xff >> (len + 1), trailers add 6 bits each
  function automatic logic [CP_W-1:0] join_seq(input int unsigned first,
                                              input int unsigned len);
    logic [CP_W-1:0] cp;
    logic [BYTE_W-1:0] lead_mask;
    int unsigned k;
    lead_mask = 8'hFF >> (len + 1);
    cp = CP_W'(seq_buf[first] & lead_mask);
    for (k = 1; k < len; k++) begin
      cp = (cp << 6) | CP_W'(seq_buf[first + k][5:0]);
    end
    return cp;
  endfunction

  function automatic res_t code_res(input logic [CP_W-1:0] cp, input logic rep);
    res_t r;
    r.code_point = cp;
    r.replaced   = rep;
    r.run_last   = 1'b0;
    r.text_last  = 1'b0;
    return r;
  endfunction

  // works out the code points one accepted byte causes and queues them
  task automatic decode_byte(input in_item_t it);
    res_t step_q [$];
    res_t tail;
    int unsigned cnt;
    int unsigned i;
    int unsigned len;
    logic [BYTE_W-1:0] c;
    if (seq_cnt == 0) begin
      if (it.text_byte < ASCII_END) begin
        step_q = {step_q, code_res(CP_W'(it.text_byte), 1'b0)};
      end else if (lead_length(it.text_byte) == 1) begin
        step_q = {step_q, code_res(CP_REPL, 1'b1)};
      end else begin
        seq_buf[0] = it.text_byte;
        seq_cnt    = 1;
        seq_need   = lead_length(it.text_byte);
      end
    end else begin
      // any byte counts as a trailer while a sequence is open
      seq_buf[seq_cnt % 4] = it.text_byte;
      seq_cnt++;
      if (seq_cnt >= seq_need || seq_cnt >= 4) begin
        len = seq_need;
        if (len < 2 || len > 4) begin
          len = seq_cnt;
        end
        step_q = {step_q, code_res(join_seq(0, len), 1'b0)};
        seq_cnt  = 0;
        seq_need = 0;
      end
    end
    // text ends inside a sequence: lead is replaced, the rest is decoded again
    if (it.end_of_text && seq_cnt > 0) begin
      cnt = (seq_cnt > 4) ? 4 : seq_cnt;
      i = 0;
      while (i < cnt) begin
        c   = seq_buf[i];
        len = lead_length(c);
        if (c < ASCII_END) begin
          step_q = {step_q, code_res(CP_W'(c), 1'b0)};
          i++;
        end else if (len == 1 || i + len > cnt) begin
          step_q = {step_q, code_res(CP_REPL, 1'b1)};
          i++;
        end else begin
          step_q = {step_q, code_res(join_seq(i, len), 1'b0)};
          i += len;
        end
      end
      seq_cnt  = 0;
      seq_need = 0;
    end
    if (step_q.size() > 0) begin
      tail = step_q.pop_back();
      tail.run_last  = 1'b1;
      tail.text_last = it.end_of_text;
      step_q = {step_q, tail};
    end
    code_points_due = {code_points_due, step_q};
  endtask

  task automatic queue_byte(input logic [BYTE_W-1:0] b, input logic eot);
    in_item_t it;
    it.text_byte   = b;
    it.end_of_text = eot;
    text_q = {text_q, it};
    bytes_queued++;
  endtask

  // mostly well-formed sequences with random payload, some strays and noise;
  // an end of text may land on any byte, which cuts sequences short
  task automatic add_sequence();
    int unsigned kind;
    int unsigned len;
    int unsigned k;
    logic [BYTE_W-1:0] b;
    kind = $urandom_range(99);
    len  = 1;
    if (kind < 28) begin
      b = 8'($urandom_range(8'h7F));
    end else if (kind < 44) begin
      b = 8'($urandom_range(8'hDF, 8'hC0));
      len = 2;
    end else if (kind < 60) begin
      b = 8'($urandom_range(8'hEF, 8'hE0));
      len = 3;
    end else if (kind < 76) begin
      b = 8'($urandom_range(8'hFF, 8'hF0));
      len = 4;
    end else if (kind < 84) begin
      b = 8'($urandom_range(8'hBF, 8'h80));
    end else begin
      b = 8'($urandom_range(8'hFF));
    end
    for (k = 0; k < len; k++) begin
      if (k > 0) begin
        if ($urandom_range(99) < 88) begin
          b = {2'b10, 6'($urandom_range(63))};
        end else begin
          b = 8'($urandom_range(8'hFF));
        end
      end
      queue_byte(b, $urandom_range(99) < 9);
    end
  endtask

  task automatic run_phase(input int src_pct, input int sink_pct, input bit directed);
    int unsigned start;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    start = bytes_queued;
    if (directed) begin
      foreach (DIRECTED[d]) begin
        queue_byte(DIRECTED[d][7:0], DIRECTED[d][8]);
      end
    end
    while (bytes_queued - start < PHASE_BYTES) begin
      add_sequence();
    end
    while (bytes_taken != bytes_queued) begin
      @(posedge clk);
    end
  endtask

  // driver: new item or new ready level at the falling edge only
  always @(negedge clk) begin : drv
    in_item_t nxt;
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      out_tready <= 1'b0;
    end else begin
      // slot is free when nothing is offered or the offer was just taken
      if (!in_tvalid || in_fire) begin
        if (text_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          nxt = text_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= nxt.text_byte;
          in_tlast  <= nxt.end_of_text;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // monitor: predict on accepted bytes, check accepted code points, watchdog
  always @(posedge clk) begin : mon
    in_item_t seen;
    res_t got;
    res_t want;
    logic moved;
    moved = 1'b0;
    in_fire <= rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      // predict first so a result given out in the same cycle as its byte would still find its expectation
      if (in_tvalid && in_tready) begin
        seen.text_byte   = in_tdata;
        seen.end_of_text = in_tlast;
        decode_byte(seen);
        bytes_taken++;
        moved = 1'b1;
      end
      if (out_tvalid && out_tready) begin
        moved = 1'b1;
        got.code_point = out_tdata[CP_W-1:0];
        got.run_last   = out_tdata[CP_W];
        got.replaced   = out_tuser;
        got.text_last  = out_tlast;
        if (code_points_due.size() == 0) begin
          errors++;
          $display("%0t: code point with none due: expected none,", $time,
                   " actual cp=%h rep=%b run=%b last=%b",
                   got.code_point, got.replaced, got.run_last, got.text_last);
        end else begin
          want = code_points_due.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: mismatch: expected cp=%h rep=%b run=%b last=%b,",
                     $time, want.code_point, want.replaced, want.run_last,
                     want.text_last,
                     " actual cp=%h rep=%b run=%b last=%b",
                     got.code_point, got.replaced, got.run_last, got.text_last);
          end
          if (out_tdata[OUT_DW-1:CP_W+1] !== '0) begin
            errors++;
            $display("%0t: tdata padding mismatch: expected %b, actual %b",
                     $time, {(OUT_DW-CP_W-1){1'b0}}, out_tdata[OUT_DW-1:CP_W+1]);
          end
        end
      end
      if (moved) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("utf8_stream_decoder_core regression: fail");
        $finish;
      end
    end
  end

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    // slow sender and a receiver that stalls often, then the reverse, then full rate
    run_phase(26, 56, 1'b1);
    run_phase(56, 26, 1'b0);
    run_phase(0, 0, 1'b0);
    while (bytes_taken != bytes_queued || code_points_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("utf8_stream_decoder_core regression: pass");
    end else begin
      $display("utf8_stream_decoder_core regression: fail");
    end
    $finish;
  end

endmodule
